// ----- hw/rtl/pbrf_pkg.sv -----
package pbrf_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COEF_BITS = 16;
  localparam int REG_BITS  = 20;

  // register indices on the config port
  localparam logic [2:0] REG_ROT_ROW_X   = 3'd0;
  localparam logic [2:0] REG_ROT_ROW_Y   = 3'd1;
  localparam logic [2:0] REG_OFFSET_X    = 3'd2;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd3;
  localparam logic [2:0] REG_CELL_SIZE   = 3'd4;
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd5;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd6;
  localparam logic [2:0] REG_Z_LIMIT     = 3'd7;

  localparam logic [47:0] ROT_ROW_X_RST = 48'd16384;
  localparam logic [47:0] ROT_ROW_Y_RST = 48'd1073741824;
  localparam logic [15:0] CELL_SIZE_RST = 16'd200;
  localparam logic [8:0]  GRID_DIM_RST  = 9'd256;
  localparam logic [19:0] Z_LIMIT_RST   = 20'd200;

  typedef enum logic [2:0] {
    RSN_KEPT      = 3'd0,
    RSN_INVALID   = 3'd1,
    RSN_OUTSIDE   = 3'd2,
    RSN_CELL_ZERO = 3'd3,
    RSN_TOO_HIGH  = 3'd4
  } reason_t;

endpackage

// ----- hw/rtl/point_bitmap_roi_filter.sv -----
// Point bitmap ROI filter.
// Input stream (in_*): tuser carries the action; 0 writes one bitmap cell, 1 classifies
// one point. Map writes give no result; every point item gives exactly one result on the
// output stream (out_*) carrying keep, the drop reason and the point's own fields.
// The bitmap must be loaded before points that read it; unwritten cells read as anything.
// Throughput: one item per cycle while the skid register is empty. QW is the quotient
// width (24 at COORD_BITS = 20). From input request to output request an item passes a
// product stage, a sum stage, a restoring divider with one quotient bit per stage
// (cell size as divisor), a grid/address stage, the bitmap read with its registered
// data, then the output register.
// The bitmap is one synchronous single-bit memory; writes and reads are issued from the
// same pipeline stage, so a map write is seen by every point behind it.
// Reset clears the pipeline, the output buffer and loads register defaults; the bitmap
// itself is not cleared.
// When the receiver stalls, one result sits in the output register and one more in a
// skid register; the pipeline then freezes and in_tready drops (registered, no
// combinational path from out_tready).
// The user must write configuration only while no item is in flight; the block does not enforce it.
module point_bitmap_roi_filter #(
  parameter int GRID_SIDE  = 256,
  parameter int COORD_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // map_address, map_byte, point_valid, point_x, point_y, point_z, point_intensity
  input  logic [((41 + 3*COORD_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic                  in_tuser,   // action
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // keep, drop_reason, out_x, out_y, out_z, out_intensity
  output logic [((20 + 3*COORD_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_addr,
  input  logic [47:0]           cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int OUT_W = ((20 + 3*CB + 7) / 8) * 8;
  localparam int PW    = CB + pbrf_pkg::COEF_BITS;
  localparam int SW    = ((PW + 2 > 34) ? PW + 2 : 34) + 1;
  localparam int NW    = SW - pbrf_pkg::FRAC_BITS;
  localparam int QW    = NW - 1;
  localparam int GW    = QW + 2;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int RAW   = (AW > 18) ? AW : 18;
  localparam int NST   = QW + 4;
  localparam int ST_C  = QW + 2;
  localparam int ST_E  = QW + 3;
  localparam int X_LSB = 25;
  localparam int ZW    = (CB > pbrf_pkg::REG_BITS) ? CB : pbrf_pkg::REG_BITS;

  typedef struct packed {
    logic          act;
    logic          pv;
    logic          mwe;
    logic [AW-1:0] wadr;
    logic          wbit;
    logic          sx;
    logic          sy;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
    logic [15:0]   inten;
  } meta_t;

  // configuration
  logic [47:0] rot_x_r, rot_y_r;
  logic [19:0] off_x_r, off_y_r, zlim_r;
  logic [15:0] cell_r;
  logic [8:0]  w_r, h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_x_r <= pbrf_pkg::ROT_ROW_X_RST;
      rot_y_r <= pbrf_pkg::ROT_ROW_Y_RST;
      off_x_r <= '0;
      off_y_r <= '0;
      cell_r  <= pbrf_pkg::CELL_SIZE_RST;
      w_r     <= pbrf_pkg::GRID_DIM_RST;
      h_r     <= pbrf_pkg::GRID_DIM_RST;
      zlim_r  <= pbrf_pkg::Z_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pbrf_pkg::REG_ROT_ROW_X:   rot_x_r <= cfg_data;
        pbrf_pkg::REG_ROT_ROW_Y:   rot_y_r <= cfg_data;
        pbrf_pkg::REG_OFFSET_X:    off_x_r <= cfg_data[19:0];
        pbrf_pkg::REG_OFFSET_Y:    off_y_r <= cfg_data[19:0];
        pbrf_pkg::REG_CELL_SIZE:   cell_r  <= cfg_data[15:0];
        pbrf_pkg::REG_GRID_WIDTH:  w_r     <= cfg_data[8:0];
        pbrf_pkg::REG_GRID_HEIGHT: h_r     <= cfg_data[8:0];
        pbrf_pkg::REG_Z_LIMIT:     zlim_r  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_valid_r, out_valid_r;
  logic [OUT_W-1:0] out_data_r, skid_data_r;

  assign en        = !skid_valid_r;
  assign in_tready = en;

  // pipeline control and payload
  logic  vld_r [NST];
  meta_t meta_r [NST];
  meta_t meta_in, meta_b;

  logic signed [CB-1:0] px, py, pz;
  logic [15:0]          map_addr;

  always_comb begin
    map_addr      = in_tdata[15:0];
    px            = in_tdata[X_LSB +: CB];
    py            = in_tdata[X_LSB + CB +: CB];
    pz            = in_tdata[X_LSB + 2*CB +: CB];
    meta_in.act   = in_tuser;
    meta_in.pv    = in_tdata[24];
    meta_in.mwe   = 64'(map_addr) < 64'(CELLS);
    meta_in.wadr  = AW'(map_addr);
    meta_in.wbit  = |in_tdata[23:16];
    meta_in.sx    = 1'b0;
    meta_in.sy    = 1'b0;
    meta_in.x     = px;
    meta_in.y     = py;
    meta_in.z     = pz;
    meta_in.inten = in_tdata[X_LSB + 3*CB +: 16];
  end

  // stage A: six products
  logic signed [PW-1:0] prx_r [3];
  logic signed [PW-1:0] pry_r [3];
  logic signed [15:0]   cx [3];
  logic signed [15:0]   cy [3];
  logic signed [CB-1:0] pv3 [3];

  always_comb begin
    pv3[0] = px;
    pv3[1] = py;
    pv3[2] = pz;
    for (int j = 0; j < 3; j++) begin
      cx[j] = rot_x_r[16*j +: 16];
      cy[j] = rot_y_r[16*j +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        prx_r[j] <= PW'(cx[j]) * PW'(pv3[j]);
        pry_r[j] <= PW'(cy[j]) * PW'(pv3[j]);
      end
    end
  end

  // stage B: sums, floor by 2^14, fold sign for unsigned division
  logic signed [SW-1:0] sum_x, sum_y, ofs_x, ofs_y;
  logic [NW-1:0]        nx, ny;
  logic [QW-1:0]        mx_r, my_r;

  always_comb begin
    ofs_x = SW'($signed(off_x_r)) <<< pbrf_pkg::FRAC_BITS;
    ofs_y = SW'($signed(off_y_r)) <<< pbrf_pkg::FRAC_BITS;
    sum_x = SW'(prx_r[0]) + SW'(prx_r[1]) + SW'(prx_r[2]) + ofs_x;
    sum_y = SW'(pry_r[0]) + SW'(pry_r[1]) + SW'(pry_r[2]) + ofs_y;
    nx    = sum_x[SW-1:pbrf_pkg::FRAC_BITS];
    ny    = sum_y[SW-1:pbrf_pkg::FRAC_BITS];
    meta_b    = meta_r[0];
    meta_b.sx = nx[NW-1];
    meta_b.sy = ny[NW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // negative n: floor(n/d) = -(((-n-1)/d)) - 1, and -n-1 is ~n
      mx_r <= nx[NW-1] ? ~nx[QW-1:0] : nx[QW-1:0];
      my_r <= ny[NW-1] ? ~ny[QW-1:0] : ny[QW-1:0];
    end
  end

  // restoring divider, one quotient bit per stage
  logic [15:0]   dsr;
  logic [15:0]   rx_r [QW];
  logic [15:0]   ry_r [QW];
  logic [QW-1:0] qx_r [QW];
  logic [QW-1:0] qy_r [QW];
  logic [15:0]   rx_nxt [QW];
  logic [15:0]   ry_nxt [QW];
  logic [QW-1:0] qx_nxt [QW];
  logic [QW-1:0] qy_nxt [QW];

  assign dsr = (cell_r == 16'd0) ? 16'd1 : cell_r;

  always_comb begin
    logic [15:0]   rxi, ryi;
    logic [QW-1:0] qxi, qyi;
    logic [16:0]   shx, shy;
    for (int k = 0; k < QW; k++) begin
      rxi = (k == 0) ? 16'd0 : rx_r[(k == 0) ? 0 : k-1];
      ryi = (k == 0) ? 16'd0 : ry_r[(k == 0) ? 0 : k-1];
      qxi = (k == 0) ? mx_r : qx_r[(k == 0) ? 0 : k-1];
      qyi = (k == 0) ? my_r : qy_r[(k == 0) ? 0 : k-1];
      shx = {rxi, qxi[QW-1]};
      shy = {ryi, qyi[QW-1]};
      if (shx >= {1'b0, dsr}) begin
        rx_nxt[k] = 16'(shx - {1'b0, dsr});
        qx_nxt[k] = {qxi[QW-2:0], 1'b1};
      end else begin
        rx_nxt[k] = shx[15:0];
        qx_nxt[k] = {qxi[QW-2:0], 1'b0};
      end
      if (shy >= {1'b0, dsr}) begin
        ry_nxt[k] = 16'(shy - {1'b0, dsr});
        qy_nxt[k] = {qyi[QW-2:0], 1'b1};
      end else begin
        ry_nxt[k] = shy[15:0];
        qy_nxt[k] = {qyi[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rx_r[k] <= rx_nxt[k];
        ry_r[k] <= ry_nxt[k];
        qx_r[k] <= qx_nxt[k];
        qy_r[k] <= qy_nxt[k];
      end
    end
  end

  // stage C: centre on the grid, bounds, cell address
  logic signed [QW:0]   qxs, qys;
  logic signed [GW-1:0] col, row, wext, hext;
  logic                 ing_r, raok_r;
  logic [RAW-1:0]       ra, ra_r;

  always_comb begin
    qxs  = meta_r[ST_C-1].sx ? ~$signed({1'b0, qx_r[QW-1]}) : $signed({1'b0, qx_r[QW-1]});
    qys  = meta_r[ST_C-1].sy ? ~$signed({1'b0, qy_r[QW-1]}) : $signed({1'b0, qy_r[QW-1]});
    wext = GW'($signed({1'b0, w_r}));
    hext = GW'($signed({1'b0, h_r}));
    col  = GW'($signed({1'b0, w_r[8:1]})) + GW'(qxs);
    row  = GW'($signed({1'b0, h_r[8:1]})) - GW'(qys);
    ra   = RAW'(col[8:0]) + RAW'(row[8:0]) * RAW'(w_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ing_r  <= !col[GW-1] && !row[GW-1] && (col < wext) && (row < hext);
      raok_r <= 64'(ra) < 64'(CELLS);
      ra_r   <= ra;
    end
  end

  // bitmap: write and read issued from stage C, data registered into stage E
  logic cell_mem_r [CELLS];
  logic rd_r, ing_e_r, raok_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (vld_r[ST_C] && !meta_r[ST_C].act && meta_r[ST_C].mwe) begin
        cell_mem_r[meta_r[ST_C].wadr] <= meta_r[ST_C].wbit;
      end
      rd_r     <= cell_mem_r[ra_r[AW-1:0]];
      ing_e_r  <= ing_r;
      raok_e_r <= raok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < NST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta_r[0] <= meta_in;
      meta_r[1] <= meta_b;
      for (int k = 2; k < NST; k++) meta_r[k] <= meta_r[k-1];
    end
  end

  // stage E: reason in priority order
  pbrf_pkg::reason_t reason;
  logic              prod;
  logic [OUT_W-1:0]  res_data;
  meta_t             me;

  always_comb begin
    me = meta_r[ST_E];
    if (!me.pv) begin
      reason = pbrf_pkg::RSN_INVALID;
    end else if (!ing_e_r) begin
      reason = pbrf_pkg::RSN_OUTSIDE;
    end else if (!(raok_e_r && rd_r)) begin
      reason = pbrf_pkg::RSN_CELL_ZERO;
    end else if (ZW'($signed(me.z)) > ZW'($signed(zlim_r))) begin
      reason = pbrf_pkg::RSN_TOO_HIGH;
    end else begin
      reason = pbrf_pkg::RSN_KEPT;
    end
    prod     = en && vld_r[ST_E] && me.act;
    res_data = OUT_W'({me.inten, me.z, me.y, me.x, reason,
                       reason == pbrf_pkg::RSN_KEPT});
  end

  // output register plus skid
  logic pop;
  assign pop = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (prod) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (prod) begin
      if (!out_valid_r || pop) begin
        out_data_r <= res_data;
      end else begin
        skid_data_r <= res_data;
      end
    end else if (pop && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  a_blocked_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (prod && out_valid_r && !out_tready) |=> skid_valid_r)
    else $error("result lost when output stalled");

  a_keep_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[0] == (out_data_r[3:1] == pbrf_pkg::RSN_KEPT)))
    else $error("keep flag disagrees with drop reason");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r[ST_E]) && $stable(ra_r))
    else $error("pipeline moved while stalled");

endmodule

// ----- verif/pbrf_checker.sv -----
`timescale 1ns / 100ps

module pbrf_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [103:0] in_tdata,
  input  logic         in_tuser,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [79:0]  out_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [47:0]  cfg_data,
  output int           pending,
  output int           fail_count
);

  typedef struct {
    logic              keep;
    pbrf_pkg::reason_t reason;
    logic [19:0]       px;
    logic [19:0]       py;
    logic [19:0]       pz;
    logic [15:0]       inten;
  } verdict_t;

  verdict_t    verdict_q[$];
  logic        cell_map [0:65535];
  logic [47:0] rot_x, rot_y;
  logic [19:0] off_x, off_y, z_lim;
  logic [15:0] cell_sz;
  logic [8:0]  grid_w, grid_h;

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint rotate_row(input logic [47:0] r, input longint x,
                                        input longint y, input longint z);
    return longint'($signed(r[15:0])) * x + longint'($signed(r[31:16])) * y
         + longint'($signed(r[47:32])) * z;
  endfunction

  function automatic pbrf_pkg::reason_t classify_point(input logic [103:0] d);
    longint x, y, z, den, mx, my, col, row, w, h;
    x = longint'($signed(d[44:25]));
    y = longint'($signed(d[64:45]));
    z = longint'($signed(d[84:65]));
    if (!d[24]) return pbrf_pkg::RSN_INVALID;
    den = ((cell_sz == 0) ? 64'sd1 : longint'(cell_sz)) * (64'sd1 <<< pbrf_pkg::FRAC_BITS);
    mx = rotate_row(rot_x, x, y, z)
       + longint'($signed(off_x)) * (64'sd1 <<< pbrf_pkg::FRAC_BITS);
    my = rotate_row(rot_y, x, y, z)
       + longint'($signed(off_y)) * (64'sd1 <<< pbrf_pkg::FRAC_BITS);
    w = longint'(grid_w);
    h = longint'(grid_h);
    col = w / 2 + floor_quot(mx, den);
    row = h / 2 - floor_quot(my, den);
    if (col < 0 || row < 0 || col >= w || row >= h) return pbrf_pkg::RSN_OUTSIDE;
    if (col + row * w >= 65536 || !cell_map[col + row * w]) return pbrf_pkg::RSN_CELL_ZERO;
    if (z > longint'($signed(z_lim))) return pbrf_pkg::RSN_TOO_HIGH;
    return pbrf_pkg::RSN_KEPT;
  endfunction

  task automatic report_mismatch(input string field, input logic [79:0] got,
                                 input logic [79:0] want);
    $display("[%0t] result mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    fail_count = fail_count + 1;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      rot_x   <= pbrf_pkg::ROT_ROW_X_RST;
      rot_y   <= pbrf_pkg::ROT_ROW_Y_RST;
      off_x   <= '0;
      off_y   <= '0;
      cell_sz <= pbrf_pkg::CELL_SIZE_RST;
      grid_w  <= pbrf_pkg::GRID_DIM_RST;
      grid_h  <= pbrf_pkg::GRID_DIM_RST;
      z_lim   <= pbrf_pkg::Z_LIMIT_RST;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pbrf_pkg::REG_ROT_ROW_X:   rot_x   <= cfg_data;
          pbrf_pkg::REG_ROT_ROW_Y:   rot_y   <= cfg_data;
          pbrf_pkg::REG_OFFSET_X:    off_x   <= cfg_data[19:0];
          pbrf_pkg::REG_OFFSET_Y:    off_y   <= cfg_data[19:0];
          pbrf_pkg::REG_CELL_SIZE:   cell_sz <= cfg_data[15:0];
          pbrf_pkg::REG_GRID_WIDTH:  grid_w  <= cfg_data[8:0];
          pbrf_pkg::REG_GRID_HEIGHT: grid_h  <= cfg_data[8:0];
          pbrf_pkg::REG_Z_LIMIT:     z_lim   <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (!in_tuser) begin
          cell_map[in_tdata[15:0]] = (in_tdata[23:16] != 0);
        end else begin
          v.reason = classify_point(in_tdata);
          v.keep   = (v.reason == pbrf_pkg::RSN_KEPT);
          v.px     = in_tdata[44:25];
          v.py     = in_tdata[64:45];
          v.pz     = in_tdata[84:65];
          v.inten  = in_tdata[100:85];
          verdict_q.insert(verdict_q.size(), v);
        end
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 80'h0);
        end else begin
          v = verdict_q.pop_front();
          if (out_tdata[0] !== v.keep)
            report_mismatch("keep", 80'(out_tdata[0]), 80'(v.keep));
          if (out_tdata[3:1] !== v.reason)
            report_mismatch("reason", 80'(out_tdata[3:1]), 80'(v.reason));
          if (out_tdata[23:4] !== v.px)
            report_mismatch("x", 80'(out_tdata[23:4]), 80'(v.px));
          if (out_tdata[43:24] !== v.py)
            report_mismatch("y", 80'(out_tdata[43:24]), 80'(v.py));
          if (out_tdata[63:44] !== v.pz)
            report_mismatch("z", 80'(out_tdata[63:44]), 80'(v.pz));
          if (out_tdata[79:64] !== v.inten)
            report_mismatch("intensity", 80'(out_tdata[79:64]), 80'(v.inten));
        end
      end
      pending <= int'(verdict_q.size());
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 200000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic [103:0] in_tdata = '0;   // map_address, map_byte, point_valid, x, y, z, intensity
  logic         in_tuser = 0;    // action
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [79:0]  out_tdata;       // keep, drop_reason, x, y, z, intensity
  logic         out_tvalid;
  logic         out_tready = 0;
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = '0;
  logic [47:0]  cfg_data = '0;

  int  pending, fail_count;
  int  tx_idle_pct = 21, rx_idle_pct = 50;
  int  cycles = 0;
  int  hold_left = 0;
  logic hold_tog = 0, hold_seen = 0;
  int  cur_cell = 200, cur_grid = 256;

  point_bitmap_roi_filter u_dut (.*);

  pbrf_checker u_chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen  <= hold_tog;
      hold_left  <= 300;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic logic [103:0] point_word(input logic ok, input logic [19:0] x,
                                              input logic [19:0] y, input logic [19:0] z,
                                              input logic [15:0] inten);
    return {3'b000, inten, z, y, x, ok, 24'h0};
  endfunction

  task automatic send_request(input logic act, input logic [103:0] d);
    logic acc;
    // idle cycle by cycle so the idle share matches the percentage
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= act;
    in_tdata  <= d;
    do begin
      @(negedge clk);
      acc = in_tready;
      @(posedge clk);
    end while (!acc);
  endtask

  task automatic write_cell(input logic [15:0] a, input logic [7:0] b);
    send_request(1'b0, {80'h0, b, a});
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_registers(input logic [47:0] rx, input logic [47:0] ry,
                                input logic [19:0] ox, input logic [19:0] oy,
                                input logic [15:0] cs, input logic [8:0] gw,
                                input logic [8:0] gh, input logic [19:0] zl);
    logic [47:0] vals [8];
    vals = '{rx, ry, {28'h0, ox}, {28'h0, oy}, {32'h0, cs}, {39'h0, gw}, {39'h0, gh},
             {28'h0, zl}};
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1;
      cfg_addr <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    cur_cell = int'(cs);
    cur_grid = int'((gw > gh) ? gw : gh);
    @(posedge clk);
  endtask

  function automatic logic [19:0] near_coord();
    longint span;
    span = longint'(cur_cell) * cur_grid / 2 + 1;
    if (span > 524287) span = 524287;
    return 20'($urandom_range(0, 32'(2 * span)) - span);
  endfunction

  task automatic random_traffic(input int n);
    logic [19:0] x, y, z;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        write_cell(16'($urandom_range(0, 127)),
                   ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          x = 20'($urandom); y = 20'($urandom); z = 20'($urandom);
        end else begin
          x = near_coord(); y = near_coord(); z = 20'($urandom_range(0, 800) - 400);
        end
        send_request(1'b1, point_word($urandom_range(0, 9) != 0, x, y, z, 16'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // later grids stay within 64 cells, so these are all that random points can reach
    for (int a = 0; a < 64; a++)
      write_cell(16'(a), ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 255)) : 8'h00);

    // origin lands on column 128, row 128 with the reset settings
    write_cell(16'd32896, 8'hFF);
    send_request(1'b1, point_word(1, 20'd0, 20'd0, 20'd0, 16'h0000));
    send_request(1'b1, point_word(1, 20'd0, 20'd0, 20'd201, 16'hFFFF));
    send_request(1'b1, point_word(1, 20'd0, 20'd0, 20'd200, 16'h5A5A));
    send_request(1'b1, point_word(1, 20'd0, 20'd0, 20'h80000, 16'hA5A5));
    write_cell(16'd32896, 8'h00);
    write_cell(16'd256, 8'h01);
    send_request(1'b1, point_word(1, 20'd0, 20'd0, 20'd0, 16'h1234));
    send_request(1'b1, point_word(0, 20'h7FFFF, 20'h80000, 20'h7FFFF, 16'hFFFF));
    send_request(1'b1, point_word(0, 20'h80000, 20'h7FFFF, 20'h80000, 16'h0000));
    send_request(1'b1, point_word(1, 20'h7FFFF, 20'd0, 20'd0, 16'h0001));
    send_request(1'b1, point_word(1, 20'h80000, 20'd0, 20'd0, 16'h0002));
    send_request(1'b1, point_word(1, 20'd0, 20'h7FFFF, 20'd0, 16'h0003));
    send_request(1'b1, point_word(1, 20'd0, 20'h80000, 20'd0, 16'h0004));
    send_request(1'b1, point_word(1, 20'd25599, -20'sd25600, 20'h7FFFF, 16'h0005));
    send_request(1'b1, point_word(1, -20'sd25600, 20'd25599, -20'sd1, 16'h0006));
    write_cell(16'hFFFF, 8'h01);
    write_cell(16'h0000, 8'h80);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph == 2) begin
        tx_idle_pct = 50; rx_idle_pct = 21;
      end else if (ph == 4) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      case (ph)
        0: load_registers(48'd16384, 48'd16384 << 16, 20'd0, 20'd0, 16'd1, 9'd1, 9'd1,
                          20'h80000);
        1: load_registers({$urandom, $urandom}, {$urandom, $urandom}, 20'h80000, 20'h80000,
                          16'd65535, 9'd8, 9'd8, 20'h7FFFF);
        2: load_registers(48'hC000 << 16, 48'd16384, 20'h7FFFF, 20'h7FFFF, 16'd300, 9'd16,
                          9'd4, 20'd0);
        default: load_registers({$urandom, $urandom}, {$urandom, $urandom},
                                20'($urandom_range(0, 4000) - 2000),
                                20'($urandom_range(0, 4000) - 2000),
                                16'($urandom_range(1, 2000)), 9'($urandom_range(1, 8)),
                                9'($urandom_range(1, 8)), 20'($urandom));
      endcase
      if (ph == 3) hold_tog <= ~hold_tog;
      random_traffic(60);
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
